FILE: rtl/eop_pkg.sv
// Package: types and constants for the Exif orientation parser.
`timescale 1ns / 1ps

package eop_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_start;
    } eop_in_t;

    typedef struct packed {
        logic [3:0] orientation;
        logic [2:0] status;
    } eop_out_t;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_LEN     = 14'b00000000000010,
        PH_EXIF    = 14'b00000000000100,
        PH_PAD     = 14'b00000000001000,
        PH_BOM     = 14'b00000000010000,
        PH_MAGIC   = 14'b00000000100000,
        PH_IFDOFF  = 14'b00000001000000,
        PH_SKIPIFD = 14'b00000010000000,
        PH_COUNT   = 14'b00000100000000,
        PH_TAG     = 14'b00001000000000,
        PH_SKIPENT = 14'b00010000000000,
        PH_SKIPVAL = 14'b00100000000000,
        PH_VALUE   = 14'b01000000000000,
        PH_DRAIN   = 14'b10000000000000
    } eop_phase_t;

    localparam logic [2:0] STAT_FOUND      = 3'd0;
    localparam logic [2:0] STAT_BAD_HEADER = 3'd1;
    localparam logic [2:0] STAT_BAD_ORDER  = 3'd2;
    localparam logic [2:0] STAT_NO_TAG     = 3'd3;
    localparam logic [2:0] STAT_BAD_VALUE  = 3'd4;

    localparam logic [31:0] EXIF_WORD     = 32'h45786966;
    localparam logic [31:0] PAD_WORD      = 32'h00000000;
    localparam logic [31:0] BOM_INTEL     = 32'h00004949;
    localparam logic [31:0] BOM_MOTOROLA  = 32'h00004D4D;
    localparam logic [31:0] TIFF_MAGIC    = 32'h0000002A;
    localparam logic [31:0] ORIENT_TAG    = 32'h00000112;
    localparam logic [31:0] TIFF_HDR_OFF  = 32'd8;
    localparam logic [31:0] MAX_ORIENT    = 32'd8;
    localparam logic [15:0] MIN_SEG_LEN   = 16'd8;
    localparam logic [16:0] ENTRY_BYTES   = 17'd12;
    localparam logic [3:0]  ORIENT_NORMAL = 4'd1;

endpackage

FILE: rtl/exif_orientation_parser.sv
// Top level: byte-stream Exif orientation tag parser for one APP1 segment.
`timescale 1ns / 1ps

// Feed the APP1 segment one byte per transaction, starting at the first
// byte of its two-byte big-endian length, with segment_start high on that
// byte. The parser checks the Exif header, pad, byte-order mark and TIFF
// magic, walks to IFD0, scans its 12-byte entries for the orientation tag
// and reads its SHORT value. On the segment's last byte it emits one
// result transaction: orientation (1..8, 1 when absent or invalid) and a
// status code. Bytes outside an open segment are dropped; segment_start
// mid-segment abandons the open segment with no result. Throughput is one
// byte per clock: each byte updates the phase, counters and collected word
// in a single registered step. Results go into a two-entry output queue,
// so byte_ready stays high while one result waits for the consumer; it
// drops only when both entries are full. Each result is registered into
// the queue as the segment's last byte is accepted.
module exif_orientation_parser
    import eop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  eop_in_t  byte_data,
    output logic     result_valid,
    input  logic     result_ready,
    output eop_out_t result_data
);

    // Parser state
    eop_phase_t  phase_reg,  phase_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] len_reg,    len_next;
    logic        le_reg,     le_next;
    logic [31:0] word_reg,   word_next;
    logic [31:0] skip_reg,   skip_next;
    logic [15:0] tags_reg,   tags_next;
    logic [3:0]  orient_reg, orient_next;
    logic [2:0]  status_reg, status_next;

    // Result queue: head entry drives the port, spare catches a second result
    eop_out_t    head_reg,   spare_reg;
    logic [1:0]  cnt_reg;

    logic        accept;
    logic        pop;
    logic        emit;
    eop_out_t    emit_data;

    assign accept       = byte_valid && byte_ready;
    assign pop          = result_valid && result_ready;
    assign byte_ready   = (cnt_reg != 2'd2);
    assign result_valid = (cnt_reg != 2'd0);
    assign result_data  = head_reg;

    always_comb
    begin
        eop_phase_t  cur;
        logic        run;
        logic        done;
        logic [31:0] v;

        phase_next  = phase_reg;
        offset_next = offset_reg;
        len_next    = len_reg;
        le_next     = le_reg;
        word_next   = word_reg;
        skip_next   = skip_reg;
        tags_next   = tags_reg;
        orient_next = orient_reg;
        status_next = status_reg;
        emit        = 1'b0;
        run         = 1'b0;
        done        = 1'b0;
        v           = '0;

        if (accept)
        begin
            if (byte_data.segment_start)
            begin
                phase_next  = PH_LEN;
                offset_next = '0;
                len_next    = '0;
                le_next     = 1'b0;
                word_next   = '0;
                skip_next   = 32'd2;
                tags_next   = '0;
                orient_next = ORIENT_NORMAL;
                status_next = STAT_FOUND;
                run         = 1'b1;
            end
            else if (phase_reg != PH_IDLE)
            begin
                run = 1'b1;
            end
        end

        cur = phase_next;

        if (run)
        begin
            offset_next = offset_next + 16'd1;

            case (cur) inside
                PH_SKIPIFD, PH_SKIPENT, PH_SKIPVAL:
                begin
                    skip_next = skip_next - 32'd1;
                    done      = (skip_next == 32'd0);
                end
                PH_DRAIN, PH_IDLE:
                begin
                    done = 1'b0;
                end
                default:
                begin
                    word_next = {word_next[23:0], byte_data.data_byte};
                    skip_next = skip_next - 32'd1;
                    done      = (skip_next == 32'd0);
                    v         = word_next;
                    if (le_next)
                    begin
                        case (cur) inside
                            PH_IFDOFF:
                                v = {word_next[7:0], word_next[15:8],
                                     word_next[23:16], word_next[31:24]};
                            PH_MAGIC, PH_COUNT, PH_TAG, PH_VALUE:
                                v = {16'd0, word_next[7:0], word_next[15:8]};
                            default:
                                v = word_next;
                        endcase
                    end
                end
            endcase

            if (done)
            begin
                // Every completed field clears the collector
                word_next = '0;
                case (cur)
                    PH_LEN:
                    begin
                        len_next = v[15:0];
                        if (v[15:0] < MIN_SEG_LEN)
                        begin
                            status_next = STAT_BAD_HEADER;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_EXIF;
                            skip_next  = 32'd4;
                        end
                    end
                    PH_EXIF:
                    begin
                        if (v != EXIF_WORD)
                        begin
                            status_next = STAT_BAD_HEADER;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_PAD;
                            skip_next  = 32'd2;
                        end
                    end
                    PH_PAD:
                    begin
                        if (v != PAD_WORD)
                        begin
                            status_next = STAT_BAD_HEADER;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_BOM;
                            skip_next  = 32'd2;
                        end
                    end
                    PH_BOM:
                    begin
                        if (v == BOM_INTEL || v == BOM_MOTOROLA)
                        begin
                            le_next    = (v == BOM_INTEL);
                            phase_next = PH_MAGIC;
                            skip_next  = 32'd2;
                        end
                        else
                        begin
                            status_next = STAT_BAD_ORDER;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                    end
                    PH_MAGIC:
                    begin
                        if (v != TIFF_MAGIC)
                        begin
                            status_next = STAT_BAD_HEADER;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_IFDOFF;
                            skip_next  = 32'd4;
                        end
                    end
                    PH_IFDOFF:
                    begin
                        // IFD offset counts from the TIFF header
                        if (v < TIFF_HDR_OFF)
                        begin
                            status_next = STAT_BAD_HEADER;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                        else if (v == TIFF_HDR_OFF)
                        begin
                            phase_next = PH_COUNT;
                            skip_next  = 32'd2;
                        end
                        else
                        begin
                            phase_next = PH_SKIPIFD;
                            skip_next  = v - TIFF_HDR_OFF;
                        end
                    end
                    PH_SKIPIFD, PH_SKIPVAL:
                    begin
                        phase_next = (cur == PH_SKIPIFD) ? PH_COUNT : PH_VALUE;
                        skip_next  = 32'd2;
                    end
                    PH_COUNT, PH_SKIPENT:
                    begin
                        if (cur == PH_COUNT)
                            tags_next = v[15:0];
                        if (cur == PH_COUNT && v[15:0] == 16'd0)
                        begin
                            status_next = STAT_NO_TAG;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                        else if ({1'b0, offset_next} + ENTRY_BYTES > {1'b0, len_next})
                        begin
                            // Next entry would run past the segment
                            status_next = STAT_NO_TAG;
                            orient_next = ORIENT_NORMAL;
                            phase_next  = PH_DRAIN;
                            skip_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_TAG;
                            skip_next  = 32'd2;
                        end
                    end
                    PH_TAG:
                    begin
                        if (v == ORIENT_TAG)
                        begin
                            // skip type and count, value sits at entry bytes 8..9
                            phase_next = PH_SKIPVAL;
                            skip_next  = 32'd6;
                        end
                        else
                        begin
                            tags_next = tags_next - 16'd1;
                            if (tags_next == 16'd0)
                            begin
                                status_next = STAT_NO_TAG;
                                orient_next = ORIENT_NORMAL;
                                phase_next  = PH_DRAIN;
                                skip_next   = '0;
                            end
                            else
                            begin
                                phase_next = PH_SKIPENT;
                                skip_next  = 32'd10;
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        if (v == 32'd0 || v > MAX_ORIENT)
                        begin
                            orient_next = ORIENT_NORMAL;
                            status_next = STAT_BAD_VALUE;
                        end
                        else
                        begin
                            orient_next = v[3:0];
                            status_next = STAT_FOUND;
                        end
                        phase_next = PH_DRAIN;
                        skip_next  = '0;
                    end
                    default:
                    begin
                        phase_next = phase_next;
                    end
                endcase
            end

            // End of segment: report and go idle
            if (phase_next != PH_LEN && offset_next >= len_next)
            begin
                if (phase_next != PH_DRAIN)
                begin
                    orient_next = ORIENT_NORMAL;
                    if (phase_next inside {PH_EXIF, PH_PAD, PH_BOM, PH_MAGIC, PH_IFDOFF})
                        status_next = STAT_BAD_HEADER;
                    else
                        status_next = STAT_NO_TAG;
                end
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
        end

        emit_data.orientation = orient_next;
        emit_data.status      = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            offset_reg <= '0;
            len_reg    <= '0;
            le_reg     <= 1'b0;
            word_reg   <= '0;
            skip_reg   <= '0;
            tags_reg   <= '0;
            orient_reg <= ORIENT_NORMAL;
            status_reg <= STAT_FOUND;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            len_reg    <= len_next;
            le_reg     <= le_next;
            word_reg   <= word_next;
            skip_reg   <= skip_next;
            tags_reg   <= tags_next;
            orient_reg <= orient_next;
            status_reg <= status_next;
        end
    end

    // Two-entry result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            case (cnt_reg)
                2'd0:
                begin
                    if (accept && emit)
                        cnt_reg <= 2'd1;
                end
                2'd1:
                begin
                    if (accept && emit && !pop)
                        cnt_reg <= 2'd2;
                    else if (!(accept && emit) && pop)
                        cnt_reg <= 2'd0;
                end
                2'd2:
                begin
                    if (pop)
                        cnt_reg <= 2'd1;
                end
                default:
                begin
                    cnt_reg <= 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cnt_reg)
            2'd0:
            begin
                if (accept && emit)
                    head_reg <= emit_data;
            end
            2'd1:
            begin
                if (accept && emit && pop)
                    head_reg <= emit_data;
                else if (accept && emit)
                    spare_reg <= emit_data;
            end
            2'd2:
            begin
                if (pop)
                    head_reg <= spare_reg;
            end
            default:
            begin
                head_reg <= head_reg;
            end
        endcase
    end

endmodule

FILE: bench/testbench.sv
// Testbench for the Exif orientation parser: directed and random segments, scoreboard check.
`timescale 1ns / 1ps

// Segments are built here byte by byte: length, "Exif", pad, byte-order mark,
// TIFF magic, IFD offset, filler up to IFD0, entry count, entries and tail.
// Each input transaction accepted by the DUT is run through a local scan model
// that tracks the same phase, offset and field state as the parser. Any result
// that model produces is queued, and every result transaction from the DUT is
// compared against the oldest queued one, field by field.
module testbench;
    import eop_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned RANDOM_BYTES = 100;
    localparam int unsigned SETTLE       = 20;
    localparam longint      TIMEOUT_NS   = 10_000_000;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     byte_valid   = 1'b0;
    logic     byte_ready;
    eop_in_t  byte_data    = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    eop_out_t result_data;

    exif_orientation_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    always #5 clk = ~clk;

    // Idling knobs, flipped by the tests.
    bit sender_gaps  = 1'b0;
    bit sink_stalls  = 1'b0;
    bit hold_request = 1'b0;   // asks the sink for one long hold-off

    int unsigned error_count     = 0;
    int unsigned bytes_sent      = 0;

    eop_out_t   expected_results[$];
    logic [7:0] seg_bytes[$];   // segment under construction

    // ------------------------------------------------------------------
    // Scan model: same state the parser keeps, advanced once per byte.
    // ------------------------------------------------------------------
    eop_phase_t  scan_phase;
    logic [15:0] seg_pos;
    logic [15:0] seg_len;
    logic        intel_order;
    logic [31:0] field_acc;
    logic [31:0] field_left;
    logic [15:0] entries_left;
    logic [3:0]  orient_acc;
    logic [2:0]  status_acc;

    function automatic void reset_scan();
        scan_phase   = PH_IDLE;
        seg_pos      = '0;
        seg_len      = '0;
        intel_order  = 1'b0;
        field_acc    = '0;
        field_left   = '0;
        entries_left = '0;
        orient_acc   = ORIENT_NORMAL;
        status_acc   = STAT_FOUND;
    endfunction

    function automatic void open_field(eop_phase_t p, logic [31:0] nbytes);
        scan_phase = p;
        field_left = nbytes;
        field_acc  = '0;
    endfunction

    // Error: orientation falls back to 1, the rest of the segment is drained.
    function automatic void abort_scan(logic [2:0] code);
        status_acc = code;
        orient_acc = ORIENT_NORMAL;
        open_field(PH_DRAIN, '0);
    endfunction

    // A full 12-byte entry must fit inside the segment before it is read.
    function automatic void start_entry();
        if ({1'b0, seg_pos} + ENTRY_BYTES > {1'b0, seg_len})
            abort_scan(STAT_NO_TAG);
        else
            open_field(PH_TAG, 2);
    endfunction

    function automatic void field_complete(logic [31:0] v);
        case (scan_phase)
            PH_LEN:
            begin
                seg_len = v[15:0];
                if (seg_len < MIN_SEG_LEN)
                    abort_scan(STAT_BAD_HEADER);
                else
                    open_field(PH_EXIF, 4);
            end
            PH_EXIF:
                if (v != EXIF_WORD) abort_scan(STAT_BAD_HEADER);
                else open_field(PH_PAD, 2);
            PH_PAD:
                if (v != PAD_WORD) abort_scan(STAT_BAD_HEADER);
                else open_field(PH_BOM, 2);
            PH_BOM:
                if (v == BOM_INTEL)
                begin
                    intel_order = 1'b1;
                    open_field(PH_MAGIC, 2);
                end
                else if (v == BOM_MOTOROLA)
                begin
                    intel_order = 1'b0;
                    open_field(PH_MAGIC, 2);
                end
                else
                    abort_scan(STAT_BAD_ORDER);
            PH_MAGIC:
                if (v != TIFF_MAGIC) abort_scan(STAT_BAD_HEADER);
                else open_field(PH_IFDOFF, 4);
            PH_IFDOFF:
                if (v < TIFF_HDR_OFF) abort_scan(STAT_BAD_HEADER);
                else if (v == TIFF_HDR_OFF) open_field(PH_COUNT, 2);
                else open_field(PH_SKIPIFD, v - TIFF_HDR_OFF);
            PH_SKIPIFD:
                open_field(PH_COUNT, 2);
            PH_COUNT:
            begin
                entries_left = v[15:0];
                if (entries_left == 16'd0) abort_scan(STAT_NO_TAG);
                else start_entry();
            end
            PH_TAG:
                if (v == ORIENT_TAG)
                    open_field(PH_SKIPVAL, 6);
                else
                begin
                    entries_left = entries_left - 16'd1;
                    if (entries_left == 16'd0) abort_scan(STAT_NO_TAG);
                    else open_field(PH_SKIPENT, 10);
                end
            PH_SKIPENT:
                start_entry();
            PH_SKIPVAL:
                open_field(PH_VALUE, 2);
            PH_VALUE:
            begin
                if (v == 32'd0 || v > MAX_ORIENT)
                begin
                    orient_acc = ORIENT_NORMAL;
                    status_acc = STAT_BAD_VALUE;
                end
                else
                begin
                    orient_acc = v[3:0];
                    status_acc = STAT_FOUND;
                end
                open_field(PH_DRAIN, '0);
            end
            default:
                ;
        endcase
    endfunction

    // One accepted byte; sets emit when it closes the segment.
    function automatic void scan_byte(input logic [7:0] b, input logic start,
                                      output bit emit, output eop_out_t res);
        eop_phase_t  p;
        logic [31:0] v;
        emit = 1'b0;
        res  = '0;
        if (start)
        begin
            reset_scan();
            open_field(PH_LEN, 2);
        end
        else if (scan_phase == PH_IDLE)
            return;

        seg_pos = seg_pos + 16'd1;
        p = scan_phase;
        if (p inside {PH_SKIPIFD, PH_SKIPENT, PH_SKIPVAL})
        begin
            field_left = field_left - 32'd1;
            if (field_left == 32'd0)
                field_complete('0);
        end
        else if (p != PH_DRAIN)
        begin
            field_acc  = {field_acc[23:0], b};
            field_left = field_left - 32'd1;
            if (field_left == 32'd0)
            begin
                v = field_acc;
                // TIFF fields follow the byte-order mark; header fields are big-endian
                if (intel_order && (p inside {PH_MAGIC, PH_IFDOFF, PH_COUNT, PH_TAG, PH_VALUE}))
                begin
                    if (p == PH_IFDOFF)
                        v = {v[7:0], v[15:8], v[23:16], v[31:24]};
                    else
                        v = {16'h0000, v[7:0], v[15:8]};
                end
                field_complete(v);
            end
        end

        if (scan_phase != PH_LEN && seg_pos >= seg_len)
        begin
            // segment ran out before a verdict
            if (scan_phase != PH_DRAIN)
            begin
                if (scan_phase inside {PH_EXIF, PH_PAD, PH_BOM, PH_MAGIC, PH_IFDOFF})
                    status_acc = STAT_BAD_HEADER;
                else
                    status_acc = STAT_NO_TAG;
                orient_acc = ORIENT_NORMAL;
            end
            res.orientation = orient_acc;
            res.status      = status_acc;
            emit            = 1'b1;
            scan_phase      = PH_IDLE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!sender_gaps)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one byte, waits for the handshake, then runs the scan model.
    // Valid stays high afterwards so back-to-back transactions need no toggle.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        bit          emit;
        eop_out_t    res;
        eop_in_t     item;
        gap = pick_gap();
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.data_byte     = b;
        item.segment_start = start;
        byte_valid <= 1'b1;
        byte_data  <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        scan_byte(b, start, emit, res);
        if (emit)
            expected_results.push_back(res);
        bytes_sent++;
    endtask

    // Sends seg_bytes[first .. last-1], segment_start on the first one.
    task automatic send_segment(input int first, input int last);
        int i;
        for (i = first; i < last; i++)
            send_byte(seg_bytes[i], i == first);
    endtask

    function automatic void push_word(input logic [31:0] v, input int nbytes,
                                      input bit intel);
        int k;
        for (k = 0; k < nbytes; k++)
            seg_bytes.push_back(intel ? v[8*k +: 8] : v[8*(nbytes-1-k) +: 8]);
    endfunction

    // Builds a complete segment; tag_slot < 0 leaves the orientation tag out.
    // The length field is patched to the real size at the end.
    function automatic void build_segment(input bit intel, input logic [31:0] ifd_ofs,
                                          input logic [15:0] count, input int entries,
                                          input int tag_slot, input logic [15:0] value,
                                          input int tail);
        int          e;
        int          filler;
        logic [15:0] tag;
        logic [15:0] total;
        seg_bytes.delete();
        push_word(32'd0, 2, 1'b0);
        push_word(EXIF_WORD, 4, 1'b0);
        push_word(PAD_WORD, 2, 1'b0);
        push_word(intel ? BOM_INTEL : BOM_MOTOROLA, 2, 1'b0);
        push_word(TIFF_MAGIC, 2, intel);
        push_word(ifd_ofs, 4, intel);
        filler = (ifd_ofs >= 8 && ifd_ofs < 64) ? int'(ifd_ofs) - 8 : 0;
        repeat (filler) seg_bytes.push_back(8'($urandom));
        push_word({16'h0000, count}, 2, intel);
        for (e = 0; e < entries; e++)
        begin
            tag = (e == tag_slot) ? ORIENT_TAG[15:0] : 16'($urandom);
            if (e != tag_slot && tag == ORIENT_TAG[15:0])
                tag ^= 16'h0001;
            push_word({16'h0000, tag}, 2, intel);
            push_word(32'd3, 2, intel);            // SHORT
            push_word(32'd1, 4, intel);
            push_word(e == tag_slot ? {16'h0000, value} : $urandom, 2, intel);
            push_word(32'd0, 2, intel);
        end
        repeat (tail) seg_bytes.push_back(8'($urandom));
        total = 16'(seg_bytes.size());
        seg_bytes[0] = total[15:8];
        seg_bytes[1] = total[7:0];
    endfunction

    function automatic void set_length(input logic [15:0] len);
        seg_bytes[0] = len[15:8];
        seg_bytes[1] = len[7:0];
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, plus the one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned span;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!sink_stalls || $urandom_range(99) < 60)
            begin
                result_ready <= 1'b1;
                span = sink_stalls ? $urandom_range(1, 8) : 1;
                repeat (span) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b0;
                span = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 3);
                repeat (span) @(posedge clk);
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Every accepted result transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        eop_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result orientation %0d status %0d",
                                          result_data.orientation, result_data.status));
            else
            begin
                want = expected_results.pop_front();
                if (result_data.orientation !== want.orientation)
                    report_mismatch($sformatf("orientation got %0d want %0d",
                                              result_data.orientation, want.orientation));
                if (result_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result_data.status, want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Stray bytes while idle, and segments shorter than a header.
    task automatic test_short_segments();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        seg_bytes = '{8'h00, 8'h00};
        send_segment(0, 2);
        seg_bytes = '{8'h00, 8'h02};
        send_segment(0, 2);
        seg_bytes = '{8'h00, 8'h07, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h12};
        send_segment(0, 7);
    endtask

    task automatic test_header_errors();
        build_segment(1'b0, 32'd8, 16'd0, 0, 0, 16'd3, 0);
        seg_bytes[2] ^= 8'h01;                       // Exif word
        send_segment(0, seg_bytes.size());
        build_segment(1'b0, 32'd8, 16'd0, 0, 0, 16'd3, 0);
        seg_bytes[7] = 8'h80;                        // pad
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'd8, 16'd0, 0, 0, 16'd3, 0);
        seg_bytes[9] = 8'h4D;                        // mixed byte-order mark
        send_segment(0, seg_bytes.size());
        build_segment(1'b0, 32'd8, 16'd0, 0, 0, 16'd3, 0);
        seg_bytes[11] = 8'h2B;                       // TIFF magic
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'd7, 16'd0, 0, 0, 16'd3, 0);   // IFD offset below 8
        send_segment(0, seg_bytes.size());
        // segment too short for the byte-order mark, then too short for IFD0
        build_segment(1'b0, 32'd8, 16'd0, 0, 0, 16'd3, 0);
        set_length(16'd8);
        send_segment(0, seg_bytes.size());
        build_segment(1'b0, 32'd20, 16'd0, 0, 0, 16'd3, 0);
        set_length(16'd22);
        send_segment(0, seg_bytes.size());
    endtask

    task automatic test_ifd_walk();
        build_segment(1'b0, 32'd8, 16'd1, 1, 0, 16'd6, 2);
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'd12, 16'd3, 3, 2, 16'd8, 0);
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'd8, 16'd1, 1, 0, 16'd1, 1);
        send_segment(0, seg_bytes.size());
        build_segment(1'b0, 32'd8, 16'd3, 3, -1, 16'd0, 1);   // tag absent
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'd8, 16'd0, 0, -1, 16'd0, 4);   // zero entry count
        send_segment(0, seg_bytes.size());
        build_segment(1'b0, 32'd8, 16'hFFFF, 1, -1, 16'd0, 3); // entry overruns segment
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'hFFFF_FFFF, 16'd1, 1, 0, 16'd2, 0); // IFD far past the end
        send_segment(0, seg_bytes.size());
        // out-of-range values
        build_segment(1'b0, 32'd8, 16'd1, 1, 0, 16'd0, 0);
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'd8, 16'd2, 2, 1, 16'd9, 0);
        send_segment(0, seg_bytes.size());
        build_segment(1'b1, 32'd9, 16'd1, 1, 0, 16'hFFFF, 0);
        send_segment(0, seg_bytes.size());
    endtask

    // segment_start in the middle abandons the open segment without a result.
    task automatic test_restart();
        build_segment(1'b0, 32'd8, 16'd1, 1, 0, 16'd5, 0);
        set_length(16'hFFFF);
        send_segment(0, 10);
        build_segment(1'b1, 32'd8, 16'd2, 2, 0, 16'd7, 0);
        send_segment(0, 20);
        send_segment(20, seg_bytes.size());
        build_segment(1'b0, 32'd8, 16'd1, 1, 0, 16'd4, 0);
        send_segment(0, seg_bytes.size());
    endtask

    // Sink holds off while short segments keep coming; the result queue fills
    // and byte_ready must drop until the sink lets go.
    task automatic test_backpressure();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (16)
        begin
            seg_bytes = '{8'h00, 8'h01};
            send_segment(0, 2);
        end
    endtask

    task automatic test_random();
        int unsigned target_bytes;
        int          n;
        int          slot;
        int          kind;
        int          cut;
        int          restart_at;
        logic [15:0] cnt;
        logic [15:0] val;
        logic [31:0] ofs;
        target_bytes   = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target_bytes)
        begin
            // occasional stretches with no idling on either side
            sender_gaps = ($urandom_range(99) < 85);
            sink_stalls = ($urandom_range(99) < 85);

            n    = $urandom_range(1, 4);
            slot = ($urandom_range(99) < 80) ? $urandom_range(0, n - 1) : -1;
            val  = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 8)) : 16'($urandom);
            cnt  = ($urandom_range(99) < 10) ? 16'($urandom_range(0, 6)) : 16'(n);
            kind = $urandom_range(99);
            if (kind < 60)      ofs = 32'd8;
            else if (kind < 95) ofs = $urandom_range(9, 24);
            else                ofs = $urandom;
            build_segment($urandom_range(1), ofs, cnt, n, slot, val, $urandom_range(0, 6));

            // mostly well-formed; the rest gets damaged one way or another
            cut        = seg_bytes.size();
            restart_at = 0;
            kind       = $urandom_range(99);
            if (kind < 8)
                seg_bytes[$urandom_range(2, cut - 1)] ^= 8'($urandom_range(1, 255));
            else if (kind < 14)
                set_length(16'($urandom_range(0, cut + 4)));
            else if (kind < 16)
                set_length(16'($urandom));
            else if (kind < 21)
                cut = $urandom_range(1, cut - 1);
            else if (kind < 26)
                restart_at = $urandom_range(1, cut - 1);

            if ($urandom_range(99) < 8)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);

            if (restart_at > 0)
            begin
                send_segment(0, restart_at);
                send_segment(restart_at, cut);
            end
            else
                send_segment(0, cut);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_scan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_segments();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_header_errors();
        test_ifd_walk();
        test_restart();
        test_backpressure();
        test_random();

        // stop offering, let everything pending drain, then settle
        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
